### design/msttu_pkg.sv
// Shared types, constants and field layouts for the motion state tamper tracker.
package msttu_pkg;

    // Default time width and register reset values
    localparam int unsigned TIME_BITS_DEF = 32;
    localparam int unsigned CFG_W         = 16;
    localparam logic [CFG_W-1:0] QUIET_TIMEOUT_RST = 16'd60;
    localparam logic [CFG_W-1:0] SETTLED_TIME_RST  = 16'd300;

    // Configuration register indexes
    localparam logic REG_QUIET_TIMEOUT = 1'b0;
    localparam logic REG_SETTLED_TIME  = 1'b1;

    // Command codes carried in the input tuser
    localparam logic CMD_SAMPLE      = 1'b0;
    localparam logic CMD_CLEAR_LATCH = 1'b1;

    // Event bit positions
    localparam int unsigned EV_SHOCK  = 0;
    localparam int unsigned EV_FALL   = 1;
    localparam int unsigned EV_START  = 2;
    localparam int unsigned EV_STOP   = 3;
    localparam int unsigned EV_ORIENT = 4;
    localparam int unsigned EV_TAMPER = 5;

    // Orientation code for an unknown face
    localparam logic [2:0] FACE_UNKNOWN = 3'd0;

    // Bus widths, padded to whole bytes
    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned OUT_TDATA_W = 96;

    // Input item, lowest field in the lowest bits (55 bits)
    typedef struct packed {
        logic [2:0]  face_now;
        logic        fall_seen;
        logic [15:0] shock_peak;
        logic        shock_seen;
        logic        is_active;
        logic        accel_valid;
        logic [31:0] sample_time;
    } t_in_item;

    // Result item, lowest field in the lowest bits (91 bits)
    typedef struct packed {
        logic        tamper_flag;
        logic [31:0] move_total;
        logic [31:0] move_duration;
        logic [15:0] shock_level;
        logic [2:0]  face_held;
        logic        is_moving;
        logic [5:0]  event_bits;
    } t_result;

    localparam int unsigned IN_ITEM_W = $bits(t_in_item);
    localparam int unsigned RESULT_W  = $bits(t_result);

endpackage

### design/msttu_core.sv
// Next-state and result logic for one item of the motion state tamper tracker.
module msttu_core
    import msttu_pkg::*;
#(
    parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_cmd,
    input  t_in_item             i_item,
    input  logic [CFG_W-1:0]     i_quiet_timeout,
    input  logic [CFG_W-1:0]     i_settled_time,
    input  logic                 i_moving,
    input  logic [2:0]           i_face,
    input  logic                 i_tamper,
    input  logic [TIME_BITS-1:0] i_last_active_at,
    input  logic [TIME_BITS-1:0] i_move_start_at,
    input  logic [TIME_BITS-1:0] i_rest_since,
    input  logic [31:0]          i_total_moved,
    output logic                 o_moving,
    output logic [2:0]           o_face,
    output logic                 o_tamper,
    output logic [TIME_BITS-1:0] o_last_active_at,
    output logic [TIME_BITS-1:0] o_move_start_at,
    output logic [TIME_BITS-1:0] o_rest_since,
    output logic [31:0]          o_total_moved,
    output t_result              o_result
);

    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] since_rest;
    logic [TIME_BITS-1:0] since_active;
    logic [TIME_BITS-1:0] move_len;
    logic                 settled;
    logic                 quiet_done;
    logic [5:0]           ev;
    logic [15:0]          level;
    logic [31:0]          dur;

    // Time differences wrap at the time width
    assign now          = TIME_BITS'(i_item.sample_time);
    assign since_rest   = now - i_rest_since;
    assign since_active = now - i_last_active_at;
    assign move_len     = i_last_active_at - i_move_start_at;
    assign settled      = !i_moving && (since_rest >= TIME_BITS'(i_settled_time));
    assign quiet_done   = since_active >= TIME_BITS'(i_quiet_timeout);

    // Apply one item to the held state
    always_comb begin
        o_moving         = i_moving;
        o_face           = i_face;
        o_tamper         = i_tamper;
        o_last_active_at = i_last_active_at;
        o_move_start_at  = i_move_start_at;
        o_rest_since     = i_rest_since;
        o_total_moved    = i_total_moved;
        ev               = '0;
        level            = '0;
        dur              = '0;

        if (i_cmd == CMD_CLEAR_LATCH) begin
            o_tamper = 1'b0;
        end else if (i_item.accel_valid) begin
            if (i_item.shock_seen) begin
                ev[EV_SHOCK] = 1'b1;
                level        = i_item.shock_peak;
            end
            if (i_item.fall_seen) begin
                ev[EV_FALL] = 1'b1;
            end

            // Start on activity, stop after the quiet timeout
            if (i_item.is_active) begin
                o_last_active_at = now;
                if (!i_moving) begin
                    o_moving        = 1'b1;
                    o_move_start_at = now;
                    ev[EV_START]    = 1'b1;
                end
            end else if (i_moving && quiet_done) begin
                dur           = 32'(move_len);
                o_moving      = 1'b0;
                o_rest_since  = now;
                o_total_moved = i_total_moved + dur;
                ev[EV_STOP]   = 1'b1;
            end

            // Track orientation; first known face is adopted silently
            if (i_item.face_now != FACE_UNKNOWN && i_item.face_now != i_face) begin
                o_face = i_item.face_now;
                if (i_face != FACE_UNKNOWN) begin
                    ev[EV_ORIENT] = 1'b1;
                    if (settled && i_item.shock_seen && !i_tamper) begin
                        o_tamper      = 1'b1;
                        ev[EV_TAMPER] = 1'b1;
                    end
                end
            end
        end
    end

    // Build the result item
    always_comb begin
        o_result.event_bits    = ev;
        o_result.is_moving     = o_moving;
        o_result.face_held     = o_face;
        o_result.shock_level   = level;
        o_result.move_duration = dur;
        o_result.move_total    = o_total_moved;
        o_result.tamper_flag   = o_tamper;
    end

endmodule

### design/motion_state_tamper_tracker_unit.sv
// Top level of the motion state tamper tracker: stream ports, state and output buffering.
// A result is registered in the result register, or in the skid register when the output stalls.
// Throughput: one item per cycle while the skid register is empty; the state update is a single registered pass.
// A two-entry output stage (result register plus skid register) keeps input
// acceptance independent of m_tready in the same cycle.
// Reset (synchronous, active low) clears motion state, orientation, latch,
// timestamps, total and buffers, and loads the register defaults 60 and 300.
module motion_state_tamper_tracker_unit
    import msttu_pkg::*;
#(
    parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // tdata: sample_time[31:0], accel_valid[32], is_active[33], shock_seen[34],
    //        shock_peak[50:35], fall_seen[51], face_now[54:52], zero[55]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // tuser: cmd[0]
    input  logic                   s_tuser,
    // output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // tdata: event_bits[5:0], is_moving[6], face_held[9:7], shock_level[25:10],
    //        move_duration[57:26], move_total[89:58], tamper_flag[90], zero[95:91]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [CFG_W-1:0]     r_quiet_timeout;
    logic [CFG_W-1:0]     r_settled_time;
    logic                 r_moving;
    logic [2:0]           r_face;
    logic                 r_tamper;
    logic [TIME_BITS-1:0] r_last_active_at;
    logic [TIME_BITS-1:0] r_move_start_at;
    logic [TIME_BITS-1:0] r_rest_since;
    logic [31:0]          r_total_moved;

    logic                 n_moving;
    logic [2:0]           n_face;
    logic                 n_tamper;
    logic [TIME_BITS-1:0] n_last_active_at;
    logic [TIME_BITS-1:0] n_move_start_at;
    logic [TIME_BITS-1:0] n_rest_since;
    logic [31:0]          n_total_moved;
    t_result              n_result;

    t_result              r_out;
    logic                 r_out_valid;
    t_result              r_skid;
    logic                 r_skid_valid;

    t_in_item             in_item;
    logic                 in_acc;
    logic                 out_take;

    assign in_item  = t_in_item'(s_tdata[IN_ITEM_W-1:0]);
    assign s_tready = !r_skid_valid;
    assign in_acc   = s_tvalid && s_tready;
    assign out_take = r_out_valid && m_tready;
    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, r_out};

    msttu_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_cmd            (s_tuser),
        .i_item           (in_item),
        .i_quiet_timeout  (r_quiet_timeout),
        .i_settled_time   (r_settled_time),
        .i_moving         (r_moving),
        .i_face           (r_face),
        .i_tamper         (r_tamper),
        .i_last_active_at (r_last_active_at),
        .i_move_start_at  (r_move_start_at),
        .i_rest_since     (r_rest_since),
        .i_total_moved    (r_total_moved),
        .o_moving         (n_moving),
        .o_face           (n_face),
        .o_tamper         (n_tamper),
        .o_last_active_at (n_last_active_at),
        .o_move_start_at  (n_move_start_at),
        .o_rest_since     (n_rest_since),
        .o_total_moved    (n_total_moved),
        .o_result         (n_result)
    );

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quiet_timeout <= QUIET_TIMEOUT_RST;
            r_settled_time  <= SETTLED_TIME_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_QUIET_TIMEOUT: r_quiet_timeout <= i_cfg_wdata;
                REG_SETTLED_TIME:  r_settled_time  <= i_cfg_wdata;
                default:           r_quiet_timeout <= r_quiet_timeout;
            endcase
        end
    end

    // Advance the tracker state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_moving         <= 1'b0;
            r_face           <= FACE_UNKNOWN;
            r_tamper         <= 1'b0;
            r_last_active_at <= '0;
            r_move_start_at  <= '0;
            r_rest_since     <= '0;
            r_total_moved    <= '0;
        end else if (in_acc) begin
            r_moving         <= n_moving;
            r_face           <= n_face;
            r_tamper         <= n_tamper;
            r_last_active_at <= n_last_active_at;
            r_move_start_at  <= n_move_start_at;
            r_rest_since     <= n_rest_since;
            r_total_moved    <= n_total_moved;
        end
    end

    // Hold results in the output register, spill to skid when stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_take) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_acc;
                    if (in_acc) begin
                        r_out <= n_result;
                    end
                end
            end else if (in_acc) begin
                r_skid       <= n_result;
                r_skid_valid <= 1'b1;
            end
        end
    end

    // The skid entry only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid without output entry");

    // A tamper event always reports the latch as set
    a_tamper_sets_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_bits[EV_TAMPER]) |-> r_out.tamper_flag)
        else $error("tamper event with latch clear");

    // Start and stop events agree with the reported motion state
    a_start_stop_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((!r_out.event_bits[EV_START] || r_out.is_moving) &&
                         (!r_out.event_bits[EV_STOP] || !r_out.is_moving)))
        else $error("start or stop event disagrees with motion state");

    // A clear command leaves the latch clear
    a_clear_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_tuser == CMD_CLEAR_LATCH) |=> !r_tamper)
        else $error("latch not cleared by clear command");

endmodule

### sim/tb.sv
// Self-checking testbench for the motion state tamper tracker: table-driven and random items.
module tb;
    import msttu_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned PHASE_ITEMS = 250;

    // One directed or random item, with an optional hand-written result
    typedef struct packed {
        logic     cmd;
        t_in_item it;
        logic     typed;
        t_result  golden;
    } stim_row_t;

    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic                   i_cfg_idx   = REG_QUIET_TIMEOUT;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    // tdata: sample_time, accel_valid, is_active, shock_seen, shock_peak, fall_seen, face_now
    logic [IN_TDATA_W-1:0]  s_tdata     = '0;
    // tuser: cmd
    logic                   s_tuser     = CMD_SAMPLE;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b1;
    // tdata: event_bits, is_moving, face_held, shock_level, move_duration, move_total,
    //        tamper_flag
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Mirror of the block's state and registers
    logic        moving_q;
    logic [2:0]  face_q;
    logic        latch_q;
    logic [31:0] last_active_q;
    logic [31:0] move_start_q;
    logic [31:0] rest_since_q;
    logic [31:0] total_q;
    logic [15:0] quiet_cfg;
    logic [15:0] settled_cfg;

    t_result     expected_reports[$];
    stim_row_t   in_flight_rows[$];
    stim_row_t   directed_rows[$];
    int unsigned mismatches = 0;
    int unsigned cycles     = 0;
    int unsigned stall_left = 0;
    int unsigned gap_pct    = 0;
    int unsigned stall_pct  = 0;
    logic        calm       = 1'b0;

    motion_state_tamper_tracker_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Advance the mirror by one item and return the report it should produce
    function automatic t_result track_motion(input logic cmd, input t_in_item it);
        t_result     r;
        logic        settled;
        logic        first_face;
        logic [31:0] rest_for;
        logic [31:0] quiet_for;
        logic [31:0] dur;
        r = '0;
        settled = 1'b0;
        if (cmd == CMD_CLEAR_LATCH) begin
            latch_q = 1'b0;
        end else if (it.accel_valid) begin
            rest_for = it.sample_time - rest_since_q;
            settled = !moving_q && (rest_for >= {16'd0, settled_cfg});
            if (it.shock_seen) begin
                r.event_bits[EV_SHOCK] = 1'b1;
                r.shock_level = it.shock_peak;
            end
            if (it.fall_seen) begin
                r.event_bits[EV_FALL] = 1'b1;
            end
            quiet_for = it.sample_time - last_active_q;
            if (it.is_active) begin
                last_active_q = it.sample_time;
                if (!moving_q) begin
                    moving_q = 1'b1;
                    move_start_q = it.sample_time;
                    r.event_bits[EV_START] = 1'b1;
                end
            end else if (moving_q && quiet_for >= {16'd0, quiet_cfg}) begin
                dur = last_active_q - move_start_q;
                moving_q = 1'b0;
                rest_since_q = it.sample_time;
                total_q = total_q + dur;
                r.move_duration = dur;
                r.event_bits[EV_STOP] = 1'b1;
            end
            if (it.face_now != FACE_UNKNOWN && it.face_now != face_q) begin
                first_face = (face_q == FACE_UNKNOWN);
                face_q = it.face_now;
                if (!first_face) begin
                    r.event_bits[EV_ORIENT] = 1'b1;
                    if (settled && it.shock_seen && !latch_q) begin
                        latch_q = 1'b1;
                        r.event_bits[EV_TAMPER] = 1'b1;
                    end
                end
            end
        end
        r.is_moving   = moving_q;
        r.face_held   = face_q;
        r.move_total  = total_q;
        r.tamper_flag = latch_q;
        return r;
    endfunction

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
            mismatches++;
        end
    endtask

    // Track registers, predict accepted items, check reports, drive the output ready
    always @(posedge i_clk) begin
        t_result   want;
        t_result   got;
        stim_row_t sent;
        if (!i_rst_n) begin
            moving_q = 1'b0;
            face_q = FACE_UNKNOWN;
            latch_q = 1'b0;
            last_active_q = '0;
            move_start_q = '0;
            rest_since_q = '0;
            total_q = '0;
            quiet_cfg = QUIET_TIMEOUT_RST;
            settled_cfg = SETTLED_TIME_RST;
            expected_reports.delete();
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_idx == REG_QUIET_TIMEOUT) begin
                    quiet_cfg = i_cfg_wdata;
                end else begin
                    settled_cfg = i_cfg_wdata;
                end
            end
            if (s_tvalid && s_tready) begin
                want = track_motion(s_tuser, t_in_item'(s_tdata[IN_ITEM_W-1:0]));
                if (in_flight_rows.size() != 0) begin
                    sent = in_flight_rows.pop_front();
                    if (sent.typed) begin
                        want = sent.golden;
                    end
                end
                expected_reports.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = t_result'(m_tdata[RESULT_W-1:0]);
                if (expected_reports.size() == 0) begin
                    $display("%0t: report with nothing expected, actual %0h", $time, got);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("event_bits", 32'(want.event_bits), 32'(got.event_bits));
                    check_field("is_moving", 32'(want.is_moving), 32'(got.is_moving));
                    check_field("face_held", 32'(want.face_held), 32'(got.face_held));
                    check_field("shock_level", 32'(want.shock_level), 32'(got.shock_level));
                    check_field("move_duration", want.move_duration, got.move_duration);
                    check_field("move_total", want.move_total, got.move_total);
                    check_field("tamper_flag", 32'(want.tamper_flag), 32'(got.tamper_flag));
                end
            end
        end
        // Stall the output side in bursts
        if (calm) begin
            m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 13) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic stim_row_t row(input logic cmd, input logic [31:0] t, input logic vld,
                                      input logic act, input logic shk, input logic [15:0] peak,
                                      input logic fall, input logic [2:0] face,
                                      input logic typed, input t_result golden);
        stim_row_t r;
        r.cmd            = cmd;
        r.it.sample_time = t;
        r.it.accel_valid = vld;
        r.it.is_active   = act;
        r.it.shock_seen  = shk;
        r.it.shock_peak  = peak;
        r.it.fall_seen   = fall;
        r.it.face_now    = face;
        r.typed          = typed;
        r.golden         = golden;
        return r;
    endfunction

    function automatic t_result res(input logic [5:0] ev, input logic mov, input logic [2:0] face,
                                    input logic [15:0] lvl, input logic [31:0] dur,
                                    input logic [31:0] total, input logic tamper);
        t_result r;
        r.event_bits    = ev;
        r.is_moving     = mov;
        r.face_held     = face;
        r.shock_level   = lvl;
        r.move_duration = dur;
        r.move_total    = total;
        r.tamper_flag   = tamper;
        return r;
    endfunction

    // Present one item, sometimes after a random gap, and hold it until accepted
    task automatic send_item(input stim_row_t r);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_flight_rows.push_back(r);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(r.it);
        s_tuser  <= r.cmd;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Drain the block, then load both registers
    task automatic write_regs(input logic [15:0] quiet, input logic [15:0] settled);
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= REG_QUIET_TIMEOUT;
        i_cfg_wdata <= quiet;
        @(posedge i_clk);
        i_cfg_idx   <= REG_SETTLED_TIME;
        i_cfg_wdata <= settled;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        stim_row_t   r;
        logic [15:0] phase_quiet   [PHASES];
        logic [15:0] phase_settled [PHASES];
        logic [31:0] t_now;
        logic [31:0] t_act;
        logic [31:0] span;
        int unsigned pick;

        phase_quiet   = '{16'd0, 16'd65535, 16'd5, 16'd60, 16'd1, 16'd30};
        phase_settled = '{16'd0, 16'd65535, 16'd20, 16'd300, 16'd65535, 16'd0};
        phase_quiet[3]   = 16'($urandom);
        phase_settled[3] = 16'($urandom_range(0, 400));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset register values
        // invalid sample and clear command with every field at its top value
        directed_rows.push_back(row(CMD_SAMPLE, 32'hFFFF_FFFF, 0, 1, 1, 16'hFFFF, 1, 3'd7, 1,
                                    res(6'h00, 0, 3'd0, 16'h0, 32'd0, 32'd0, 0)));
        directed_rows.push_back(row(CMD_CLEAR_LATCH, 32'hFFFF_FFFF, 1, 1, 1, 16'hFFFF, 1, 3'd7,
                                    1, res(6'h00, 0, 3'd0, 16'h0, 32'd0, 32'd0, 0)));
        // first orientation is adopted quietly
        directed_rows.push_back(row(CMD_SAMPLE, 32'd100, 1, 0, 1, 16'hFFFF, 1, 3'd3, 1,
                                    res(6'h03, 0, 3'd3, 16'hFFFF, 32'd0, 32'd0, 0)));
        // settled tag, shock and reorientation set the latch
        directed_rows.push_back(row(CMD_SAMPLE, 32'd400, 1, 0, 1, 16'h1234, 0, 3'd5, 1,
                                    res(6'h31, 0, 3'd5, 16'h1234, 32'd0, 32'd0, 1)));
        // latch already set: no second tamper event
        directed_rows.push_back(row(CMD_SAMPLE, 32'd401, 1, 0, 1, 16'h0001, 0, 3'd6, 1,
                                    res(6'h11, 0, 3'd6, 16'h0001, 32'd0, 32'd0, 1)));
        directed_rows.push_back(row(CMD_CLEAR_LATCH, 32'd0, 0, 0, 0, 16'h0, 0, 3'd0, 1,
                                    res(6'h00, 0, 3'd6, 16'h0, 32'd0, 32'd0, 0)));
        // start, keep moving with an unknown face, stop exactly at the quiet edge
        directed_rows.push_back(row(CMD_SAMPLE, 32'd402, 1, 1, 0, 16'h0, 0, 3'd0, 1,
                                    res(6'h04, 1, 3'd6, 16'h0, 32'd0, 32'd0, 0)));
        directed_rows.push_back(row(CMD_SAMPLE, 32'd430, 1, 1, 0, 16'h0, 0, 3'd0, 1,
                                    res(6'h00, 1, 3'd6, 16'h0, 32'd0, 32'd0, 0)));
        directed_rows.push_back(row(CMD_SAMPLE, 32'd490, 1, 0, 0, 16'h0, 0, 3'd0, 1,
                                    res(6'h08, 0, 3'd6, 16'h0, 32'd28, 32'd28, 0)));
        // timestamp wraps: orientation change without shock
        directed_rows.push_back(row(CMD_SAMPLE, 32'h0000_0010, 1, 0, 0, 16'h0, 0, 3'd2, 1,
                                    res(6'h10, 0, 3'd2, 16'h0, 32'd0, 32'd28, 0)));
        // movement spanning the wrap of the timestamp
        directed_rows.push_back(row(CMD_SAMPLE, 32'hFFFF_FFF0, 1, 1, 0, 16'h0, 0, 3'd0, 1,
                                    res(6'h04, 1, 3'd2, 16'h0, 32'd0, 32'd28, 0)));
        directed_rows.push_back(row(CMD_SAMPLE, 32'h0000_0020, 1, 1, 0, 16'h0, 0, 3'd0, 1,
                                    res(6'h00, 1, 3'd2, 16'h0, 32'd0, 32'd28, 0)));
        directed_rows.push_back(row(CMD_SAMPLE, 32'h0000_005C, 1, 0, 0, 16'h0, 0, 3'd0, 1,
                                    res(6'h08, 0, 3'd2, 16'h0, 32'd48, 32'd76, 0)));
        // long movements that wrap the running total
        directed_rows.push_back(row(CMD_SAMPLE, 32'h0000_0100, 1, 1, 0, 16'h0, 0, 3'd0, 0, '0));
        directed_rows.push_back(row(CMD_SAMPLE, 32'hF000_0000, 1, 1, 0, 16'h0, 0, 3'd0, 0, '0));
        directed_rows.push_back(row(CMD_SAMPLE, 32'hF000_003C, 1, 0, 0, 16'h0, 0, 3'd0, 0, '0));
        directed_rows.push_back(row(CMD_SAMPLE, 32'hF000_0040, 1, 1, 0, 16'h0, 0, 3'd0, 0, '0));
        directed_rows.push_back(row(CMD_SAMPLE, 32'hE000_0000, 1, 1, 0, 16'h0, 0, 3'd0, 0, '0));
        directed_rows.push_back(row(CMD_SAMPLE, 32'hE000_003C, 1, 0, 1, 16'h0, 1, 3'd1, 0, '0));
        directed_rows.push_back(row(CMD_SAMPLE, 32'hE000_0040, 1, 0, 0, 16'h0, 1, 3'd4, 0, '0));
        foreach (directed_rows[k]) begin
            send_item(directed_rows[k]);
        end

        // Random part, one register setting per phase
        t_now = 32'hE000_0100;
        t_act = t_now;
        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            write_regs(phase_quiet[ph], phase_settled[ph]);
            calm = (ph == PHASES - 1);
            span = 32'(phase_quiet[ph]) + 32'(phase_settled[ph]);
            for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0) begin
                    pick = $urandom_range(0, 3);
                    gap_pct   = (pick == 0) ? 0 : (pick == 1) ? 0 : (pick == 2) ? 10 : 35;
                    stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
                end
                // advance the timestamp in small or larger steps, sometimes to an edge or to a random value
                pick = $urandom_range(0, 19);
                if (pick < 8) begin
                    t_now = t_now + $urandom_range(0, 20);
                end else if (pick < 13) begin
                    t_now = t_now + $urandom_range(0, 2 * span + 2);
                end else if (pick < 16) begin
                    t_now = t_act + 32'(phase_quiet[ph]) - $urandom_range(0, 1);
                end else if (pick < 19) begin
                    t_now = t_now + 32'(phase_settled[ph]) + $urandom_range(0, 1);
                end else begin
                    t_now = $urandom;
                end
                r = row(($urandom_range(0, 19) == 0) ? CMD_CLEAR_LATCH : CMD_SAMPLE, t_now,
                        $urandom_range(0, 99) < 88, $urandom_range(0, 99) < 40,
                        $urandom_range(0, 99) < 25, 16'($urandom),
                        $urandom_range(0, 99) < 12, 3'($urandom_range(0, 7)), 0, '0);
                if ($urandom_range(0, 1) == 0) begin
                    r.it.face_now = face_q;
                end
                if (r.cmd == CMD_SAMPLE && r.it.accel_valid && r.it.is_active) begin
                    t_act = t_now;
                end
                send_item(r);
            end
        end

        // Drain and report
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
